/* design/cca_pkg.sv */
`timescale 1ns / 1ps

package cca_pkg;

	// Map geometry
	localparam int CELL_COUNT = 1024;
	localparam int OWNER_BITS = 16;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int CNT_W      = $clog2(CELL_COUNT + 1);

	// Fixed field widths
	localparam int CMD_W    = 1;
	localparam int ID_W     = 16;
	localparam int RUN_W    = 11;
	localparam int STATUS_W = 2;
	localparam int START_W  = 10;
	localparam int FREED_W  = 11;
	localparam int POLICY_W = 2;

	// Request kinds
	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BAD     = 2'd2;

	// Placement policies (the unused code acts as first fit)
	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [ID_W-1:0]  owner_id;
		logic [RUN_W-1:0] run_length;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [START_W-1:0]  run_start;
		logic [FREED_W-1:0]  cells_freed;
	} res_t;

	typedef struct packed {
		logic                  we;
		logic [ADDR_W-1:0]     waddr;
		logic [OWNER_BITS-1:0] wdata;
		logic                  re;
		logic [ADDR_W-1:0]     raddr;
	} mem_req_t;

endpackage

/* design/cca_if.sv */
`timescale 1ns / 1ps

interface cca_req_if
	import cca_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [ID_W-1:0]  owner_id;
	logic [RUN_W-1:0] run_length;

	modport source (output valid, command, owner_id, run_length, input ready);
	modport sink (input valid, command, owner_id, run_length, output ready);
endinterface

interface cca_rsp_if
	import cca_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [START_W-1:0]  run_start;
	logic [FREED_W-1:0]  cells_freed;

	modport source (output valid, status, run_start, cells_freed, input ready);
	modport sink (input valid, status, run_start, cells_freed, output ready);
endinterface

/* design/cca_ram.sv */
`timescale 1ns / 1ps

module cca_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/cca_engine.sv */
`timescale 1ns / 1ps

module cca_engine
	import cca_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [POLICY_W-1:0]   policy,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  res_valid,
	input  logic                  res_take,
	output res_t                  res,
	output mem_req_t              mem,
	input  logic [OWNER_BITS-1:0] rdata
);

	localparam int CMP_W = (CNT_W > RUN_W) ? CNT_W : RUN_W;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

	typedef enum logic [6:0] {
		S_INIT  = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_CLOSE = 7'b0001000,
		S_FILL  = 7'b0010000,
		S_CLR   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t                state_q;
	logic [ADDR_W-1:0]     cnt_q;
	logic                  issue_q;
	logic                  vld_s1;
	logic                  last_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [OWNER_BITS-1:0] owner_q;
	logic [RUN_W-1:0]      want_q;
	logic [CNT_W-1:0]      hole_len_q;
	logic [ADDR_W-1:0]     hole_start_q;
	logic                  have_q;
	logic [CNT_W-1:0]      best_len_q;
	logic [ADDR_W-1:0]     best_start_q;
	logic [ADDR_W-1:0]     fill_addr_q;
	logic [RUN_W-1:0]      remain_q;
	logic [CNT_W-1:0]      freed_q;
	res_t                  res_q;

	logic                  req_fire;
	logic                  bad_req;
	logic                  cell_free;
	logic                  owner_hit;
	logic                  close_hole;
	logic                  take_hole;
	logic                  nhave;
	logic [CNT_W-1:0]      nbest_len;
	logic [ADDR_W-1:0]     nbest_start;
	logic                  fail;

	// Decide whether a closed hole replaces the current choice
	function automatic logic better_hole(
		input logic [POLICY_W-1:0] pol,
		input logic [CNT_W-1:0]    len,
		input logic [RUN_W-1:0]    want,
		input logic                have,
		input logic [CNT_W-1:0]    blen
	);
		logic fits;
		fits = CMP_W'(len) >= CMP_W'(want);
		priority if (pol == POL_WORST) begin
			return !have || (len > blen);
		end else if (!fits) begin
			return 1'b0;
		end else if (pol == POL_BEST) begin
			return !have || (len < blen);
		end else begin
			return !have;
		end
	endfunction

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign bad_req   = (req.owner_id[OWNER_BITS-1:0] == '0)
		|| ((req.command == CMD_ALLOC) && (req.run_length == '0));
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	assign cell_free = (rdata == '0);
	assign owner_hit = vld_s1 && (rdata == owner_q);

	// Close a hole on a used cell or at the end of the map
	always_comb begin
		close_hole = (hole_len_q != '0)
			&& (((state_q == S_SCAN) && vld_s1 && !cell_free) || (state_q == S_CLOSE));
		take_hole   = close_hole && better_hole(policy, hole_len_q, want_q, have_q, best_len_q);
		nhave       = have_q || take_hole;
		nbest_len   = take_hole ? hole_len_q : best_len_q;
		nbest_start = take_hole ? hole_start_q : best_start_q;
		fail        = !nhave || (CMP_W'(nbest_len) < CMP_W'(want_q));
	end

	// Drive the memory port
	always_comb begin
		mem       = '0;
		mem.re    = issue_q;
		mem.raddr = cnt_q;
		unique case (state_q)
			S_INIT: begin
				mem.we    = 1'b1;
				mem.waddr = cnt_q;
			end
			S_CLR: begin
				mem.we    = owner_hit;
				mem.waddr = addr_s1;
			end
			S_FILL: begin
				mem.we    = 1'b1;
				mem.waddr = fill_addr_q;
				mem.wdata = owner_q;
			end
			default: begin
				mem.we = 1'b0;
			end
		endcase
	end

	// Advance the read stream and the data stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			addr_s1 <= '0;
		end else begin
			vld_s1  <= issue_q;
			last_s1 <= issue_q && (cnt_q == LAST_ADDR);
			addr_s1 <= cnt_q;
		end
	end

	// Sequence the clearing pass, scans, fill and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cnt_q        <= '0;
			issue_q      <= 1'b0;
			owner_q      <= '0;
			want_q       <= '0;
			hole_len_q   <= '0;
			hole_start_q <= '0;
			have_q       <= 1'b0;
			best_len_q   <= '0;
			best_start_q <= '0;
			fill_addr_q  <= '0;
			remain_q     <= '0;
			freed_q      <= '0;
			res_q        <= '0;
		end else begin
			if (issue_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_ADDR) begin
					issue_q <= 1'b0;
				end
			end
			unique case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						if (bad_req) begin
							res_q   <= '{status: STAT_BAD, run_start: '0, cells_freed: '0};
							state_q <= S_DONE;
						end else begin
							owner_q    <= req.owner_id[OWNER_BITS-1:0];
							want_q     <= req.run_length;
							cnt_q      <= '0;
							issue_q    <= 1'b1;
							hole_len_q <= '0;
							have_q     <= 1'b0;
							best_len_q <= '0;
							freed_q    <= '0;
							state_q    <= (req.command == CMD_CLEAR) ? S_CLR : S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (vld_s1) begin
						if (cell_free) begin
							if (hole_len_q == '0) begin
								hole_start_q <= addr_s1;
							end
							hole_len_q <= hole_len_q + 1'b1;
						end else begin
							hole_len_q <= '0;
						end
						have_q       <= nhave;
						best_len_q   <= nbest_len;
						best_start_q <= nbest_start;
						if (last_s1) begin
							state_q <= S_CLOSE;
						end
					end
				end
				S_CLOSE: begin
					if (fail) begin
						res_q   <= '{status: STAT_NOSPACE, run_start: '0, cells_freed: '0};
						state_q <= S_DONE;
					end else begin
						best_start_q <= nbest_start;
						fill_addr_q  <= nbest_start;
						remain_q     <= want_q;
						state_q      <= S_FILL;
					end
				end
				S_FILL: begin
					fill_addr_q <= fill_addr_q + 1'b1;
					remain_q    <= remain_q - 1'b1;
					if (remain_q == RUN_W'(1)) begin
						res_q   <= '{status: STAT_DONE, run_start: START_W'(best_start_q),
							cells_freed: '0};
						state_q <= S_DONE;
					end
				end
				S_CLR: begin
					if (owner_hit) begin
						freed_q <= freed_q + 1'b1;
					end
					if (vld_s1 && last_s1) begin
						res_q   <= '{status: STAT_DONE, run_start: '0,
							cells_freed: FREED_W'(freed_q + CNT_W'(owner_hit))};
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

endmodule

/* design/contiguous_cell_allocator.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Payload
// req       in   valid / ready    command, owner_id, run_length
// rsp       out  valid / ready    status, run_start, cells_freed
// cfg       in   cfg_we           cfg_wdata (fit_policy)
//
// After reset a clearing pass writes zero to all 1024 cells, with req.ready low.
// A bad request skips the map; a clear reads the map one cell per cycle through the
// single read port; an allocate scans the whole map, then writes each placed cell
// through the write port.
// The result waits in an output register, so a stalled rsp does not hold up the next request.

module contiguous_cell_allocator
	import cca_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [POLICY_W-1:0] cfg_wdata,
	cca_req_if.sink             req,
	cca_rsp_if.source           rsp
);

	logic [POLICY_W-1:0]   policy_q;
	req_t                  req_pl;
	logic                  eng_ready;
	logic                  res_valid;
	logic                  res_take;
	res_t                  res;
	mem_req_t              mem_req;
	logic [OWNER_BITS-1:0] rdata;
	logic                  rsp_valid_q;
	res_t                  rsp_q;

	// Hold the placement policy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIRST;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	assign req_pl    = '{command: req.command, owner_id: req.owner_id,
		run_length: req.run_length};
	assign req.ready = eng_ready;

	cca_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.policy    (policy_q),
		.req_valid (req.valid),
		.req_ready (eng_ready),
		.req       (req_pl),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem       (mem_req),
		.rdata     (rdata)
	);

	cca_ram #(
		.WIDTH (OWNER_BITS),
		.DEPTH (CELL_COUNT)
	) u_map (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	// Load the output register when it is empty or being drained
	assign res_take = res_valid && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.run_start   = rsp_q.run_start;
	assign rsp.cells_freed = rsp_q.cells_freed;

`ifndef ASSERT_OFF
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while one is in flight");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && req.ready))
		else $error("cell map written while idle");

	a_start_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != STAT_DONE) |-> (rsp.run_start == '0)
			&& (rsp.cells_freed == '0))
		else $error("failed request carries a start or count");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status == STAT_DONE) || (rsp.status == STAT_NOSPACE)
			|| (rsp.status == STAT_BAD))
		else $error("undefined status code");
`endif

endmodule
